// File: src/btr_pkg.sv
`default_nettype none
package btr_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [15:0] FRAC_ROUND = 16'hFFFF;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_X_STEP        = 2'd2;
  localparam logic [1:0] REG_Y_STEP        = 2'd3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef logic [7:0] chan_t;
  typedef chan_t [3:0] pixel_t;

  // a + floor((b - a) * f / 65536), rounding toward minus infinity
  function automatic chan_t lerp_byte(input chan_t a, input chan_t b, input logic [15:0] f);
    logic [7:0]  d;
    logic [23:0] p;
    logic [24:0] q;
    chan_t       r;
    if (b >= a) begin
      d = b - a;
      p = d * f;
      r = a + p[23:16];
    end else begin
      d = a - b;
      p = d * f;
      q = {1'b0, p} + {9'd0, FRAC_ROUND};
      r = a - q[23:16];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/bilinear_texture_resampler.sv
`default_nettype none
// Bilinear texture resampler.
// Configure source_width, source_height, x_step and y_step (16.16) over the
// APB port while idle. Then issue requests on start: mode 0 loads pixel
// (col, row) into the frame store, mode 1 asks for output pixel (col, row).
// busy is always low: one request is taken every cycle, loads and output
// requests freely mixed. A request sees every load issued before it.
// Each output request gives one result on strobe after its multiply, frame
// store read, horizontal lerp and vertical lerp; loads give none.
// Throughput is one request per cycle: the frame store is split into four
// single-port banks by column and row parity, so the four neighbors come
// from one read in each bank.
// The receiver cannot stall; a result is on the ports for one cycle only.
// Reset clears the registers to width 1, height 1, steps 1.0 and empties
// the pipeline; the frame store is not cleared and must be loaded before
// it is sampled.
module bilinear_texture_resampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [9:0]  col,
  input  wire logic [9:0]  row,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  output logic             strobe,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue,
  output logic      [7:0]  out_alpha
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HCW = (CW > 1) ? CW - 1 : 1;
  localparam int HRW = (RW > 1) ? RW - 1 : 1;
  localparam int BANK_DEPTH = (1 << HCW) * (1 << HRW);
  localparam int AW = HCW + HRW;

  // configuration
  logic [8:0]  source_width;
  logic [8:0]  source_height;
  logic [24:0] x_step;
  logic [24:0] y_step;
  logic        cfg_we;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 9'd1;
      source_height <= 9'd1;
      x_step        <= 25'h10000;
      y_step        <= 25'h10000;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        btr_pkg::REG_SOURCE_WIDTH:  source_width  <= pwdata[8:0];
        btr_pkg::REG_SOURCE_HEIGHT: source_height <= pwdata[8:0];
        btr_pkg::REG_X_STEP:        x_step        <= pwdata[24:0];
        btr_pkg::REG_Y_STEP:        y_step        <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      btr_pkg::REG_SOURCE_WIDTH:  prdata = {23'd0, source_width};
      btr_pkg::REG_SOURCE_HEIGHT: prdata = {23'd0, source_height};
      btr_pkg::REG_X_STEP:        prdata = {7'd0, x_step};
      btr_pkg::REG_Y_STEP:        prdata = {7'd0, y_step};
      default:                    prdata = 32'd0;
    endcase
  end

  // stage 1: positions
  logic             accept;
  logic             v1;
  logic             mode1;
  logic [9:0]       col1;
  logic [9:0]       row1;
  btr_pkg::pixel_t  pix1;
  logic [34:0]      hx1;
  logic [34:0]      vy1;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    mode1 <= mode;
    col1  <= col;
    row1  <= row;
    pix1  <= {in_alpha, in_green, in_blue, in_red};
    hx1   <= col * x_step;
    vy1   <= row * y_step;
  end

  // fix byte order: channel 0 is red in the frame word
  btr_pkg::pixel_t pix1_word;
  assign pix1_word = {pix1[3], pix1[1], pix1[2], pix1[0]};

  // stage 2: clamp, bank addressing, frame store access
  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic [8:0]  endx;
  logic [8:0]  endy;
  logic [18:0] xi;
  logic [18:0] yi;
  logic        hedge;
  logic        vedge;
  logic [8:0]  x0;
  logic [8:0]  y0;
  logic [9:0]  x1;
  logic [9:0]  y1;
  logic [HCW-1:0] xa_even;
  logic [HCW-1:0] xa_odd;
  logic [HRW-1:0] ya_even;
  logic [HRW-1:0] ya_odd;
  logic        load_ok;
  logic [3:0]  bank_we;
  logic [AW-1:0] bank_addr [4];
  logic [31:0] bank_rdata [4];

  always_comb begin
    if (source_width == 9'd0) begin
      w_eff = 9'd1;
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = source_width;
    end
    if (source_height == 9'd0) begin
      h_eff = 9'd1;
    end else if (32'(source_height) > 32'(MAX_HEIGHT)) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = source_height;
    end
  end

  assign endx  = w_eff - 9'd1;
  assign endy  = h_eff - 9'd1;
  assign xi    = hx1[34:16];
  assign yi    = vy1[34:16];
  assign hedge = xi >= {10'd0, endx};
  assign vedge = yi >= {10'd0, endy};
  assign x0    = hedge ? endx : xi[8:0];
  assign y0    = vedge ? endy : yi[8:0];
  assign x1    = {1'b0, x0} + 10'd1;
  assign y1    = {1'b0, y0} + 10'd1;

  always_comb begin
    if (x0[0]) begin
      xa_odd  = HCW'(x0 >> 1);
      xa_even = HCW'(x1 >> 1);
    end else begin
      xa_even = HCW'(x0 >> 1);
      xa_odd  = HCW'(x1 >> 1);
    end
    if (y0[0]) begin
      ya_odd  = HRW'(y0 >> 1);
      ya_even = HRW'(y1 >> 1);
    end else begin
      ya_even = HRW'(y0 >> 1);
      ya_odd  = HRW'(y1 >> 1);
    end
  end

  assign load_ok = v1 && (mode1 == btr_pkg::MODE_LOAD)
                && (32'(col1) < 32'(MAX_WIDTH)) && (32'(row1) < 32'(MAX_HEIGHT));

  // bank index is {row parity, column parity}
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = load_ok && (2'(b) == {row1[0], col1[0]});
      if (mode1 == btr_pkg::MODE_LOAD) begin
        bank_addr[b] = {HRW'(row1 >> 1), HCW'(col1 >> 1)};
      end else begin
        bank_addr[b] = {(b >= 2) ? ya_odd : ya_even, (b % 2 == 1) ? xa_odd : xa_even};
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    btr_ram #(
      .WIDTH(32),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[g]),
      .addr (bank_addr[g]),
      .wdata(pix1_word),
      .rdata(bank_rdata[g])
    );
  end

  logic        v2;
  logic        xpar2;
  logic        ypar2;
  logic [15:0] hfrac2;
  logic [15:0] vfrac2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && (mode1 == btr_pkg::MODE_REQUEST);
    end
    xpar2  <= x0[0];
    ypar2  <= y0[0];
    hfrac2 <= hedge ? 16'd0 : hx1[15:0];
    vfrac2 <= vedge ? 16'd0 : vy1[15:0];
  end

  // stage 3: horizontal lerp on top and bottom rows
  btr_pkg::pixel_t tl, tr, bl, br;
  logic [1:0] i_tl, i_tr, i_bl, i_br;

  assign i_tl = {ypar2, xpar2};
  assign i_tr = {ypar2, ~xpar2};
  assign i_bl = {~ypar2, xpar2};
  assign i_br = {~ypar2, ~xpar2};
  assign tl = bank_rdata[i_tl];
  assign tr = bank_rdata[i_tr];
  assign bl = bank_rdata[i_bl];
  assign br = bank_rdata[i_br];

  logic            v3;
  logic [15:0]     vfrac3;
  btr_pkg::pixel_t top3;
  btr_pkg::pixel_t bot3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    vfrac3 <= vfrac2;
    for (int c = 0; c < 4; c++) begin
      top3[c] <= btr_pkg::lerp_byte(tl[c], tr[c], hfrac2);
      bot3[c] <= btr_pkg::lerp_byte(bl[c], br[c], hfrac2);
    end
  end

  // stage 4: vertical lerp into the result register
  btr_pkg::pixel_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v3;
    end
    for (int c = 0; c < 4; c++) begin
      res[c] <= btr_pkg::lerp_byte(top3[c], bot3[c], vfrac3);
    end
  end

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && (mode == btr_pkg::MODE_REQUEST), 4))
    else $error("result without a matching output request");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == btr_pkg::MODE_LOAD)) |=> ##3 !strobe)
    else $error("load produced a result");

  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("frame store write conflict");

endmodule
`default_nettype wire

// File: src/btr_ram.sv
`default_nettype none
module btr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: verif/btr_checker.sv
`default_nettype none
module btr_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        mode,
  input  wire logic [9:0]  col,
  input  wire logic [9:0]  row,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  input  wire logic        strobe,
  input  wire logic [7:0]  out_red,
  input  wire logic [7:0]  out_green,
  input  wire logic [7:0]  out_blue,
  input  wire logic [7:0]  out_alpha,
  output int               errors,
  output int               pending,
  output int               results
);

  localparam int FRAME_W = 256;
  localparam int FRAME_H = 256;

  btr_pkg::pixel_t frame_mem [0:FRAME_W*FRAME_H-1];
  logic [8:0]      width_reg, height_reg;
  logic [24:0]     xstep_reg, ystep_reg;
  btr_pkg::pixel_t expected_pixels [$];

  function automatic btr_pkg::chan_t blend(input btr_pkg::chan_t a, input btr_pkg::chan_t b,
                                           input logic [15:0] f);
    int unsigned t;
    if (b >= a) begin
      t = ((b - a) * f) >> 16;
      return a + t[7:0];
    end
    t = ((a - b) * f + 32'hFFFF) >> 16;
    return a - t[7:0];
  endfunction

  function automatic int unsigned clip_dim(input logic [8:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic btr_pkg::chan_t row_sample(input int unsigned y, input logic [63:0] hx,
                                                input int unsigned w, input int ch);
    logic [63:0] xi;
    xi = hx >> 16;
    if (xi < w - 1)
      return blend(frame_mem[y*FRAME_W + xi][ch], frame_mem[y*FRAME_W + xi + 1][ch], hx[15:0]);
    return frame_mem[y*FRAME_W + w - 1][ch];
  endfunction

  function automatic btr_pkg::pixel_t resample(input logic [9:0] c, input logic [9:0] r);
    int unsigned     w, h;
    logic [63:0]     hx, vy, yi;
    btr_pkg::pixel_t p;
    w  = clip_dim(width_reg, FRAME_W);
    h  = clip_dim(height_reg, FRAME_H);
    hx = 64'(c) * 64'(xstep_reg);
    vy = 64'(r) * 64'(ystep_reg);
    yi = vy >> 16;
    for (int ch = 0; ch < 4; ch++) begin
      if (yi < h - 1)
        p[ch] = blend(row_sample(32'(yi), hx, w, ch), row_sample(32'(yi + 1), hx, w, ch),
                      vy[15:0]);
      else
        p[ch] = row_sample(h - 1, hx, w, ch);
    end
    return p;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    btr_pkg::pixel_t got, want;
    if (rst) begin
      width_reg  <= 9'd1;
      height_reg <= 9'd1;
      xstep_reg  <= 25'h10000;
      ystep_reg  <= 25'h10000;
      expected_pixels.delete();
      errors  <= 0;
      results <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          btr_pkg::REG_SOURCE_WIDTH:  width_reg  <= pwdata[8:0];
          btr_pkg::REG_SOURCE_HEIGHT: height_reg <= pwdata[8:0];
          btr_pkg::REG_X_STEP:        xstep_reg  <= pwdata[24:0];
          btr_pkg::REG_Y_STEP:        ystep_reg  <= pwdata[24:0];
          default: ;
        endcase
      end
      if (strobe) begin
        got = {out_alpha, out_blue, out_green, out_red};
        results <= results + 1;
        if (expected_pixels.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("pixel mismatch: expected rgba %h %h %h %h, got %h %h %h %h",
                       want[0], want[1], want[2], want[3], got[0], got[1], got[2], got[3]);
          end
        end
      end
      if (start && !busy) begin
        if (mode == btr_pkg::MODE_REQUEST)
          expected_pixels = {expected_pixels, resample(col, row)};
        else if (col < FRAME_W && row < FRAME_H)
          frame_mem[row*FRAME_W + col] = {in_alpha, in_blue, in_green, in_red};
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = btr_pkg::MODE_LOAD;
  logic [9:0]  col = '0, row = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic        strobe;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  int          errors, pending, results;

  bit          written [0:65535];
  int          burst_left = 0;
  int          sent = 0;
  int          idle_cycles = 0;
  int          eff_w = 1, eff_h = 1;

  always #1 clk = ~clk;

  bilinear_texture_resampler DUT (.*);

  btr_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic m, input logic [9:0] c, input logic [9:0] r,
                              input logic [31:0] px);
    start <= 1'b1;
    mode  <= m;
    col   <= c;
    row   <= r;
    {in_alpha, in_blue, in_green, in_red} <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (m == btr_pkg::MODE_LOAD && c < 256 && r < 256) written[r*256 + c] = 1'b1;
    // end the burst, mostly with a random gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3, 0) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_pixel(input int c, input int r);
    send_request(btr_pkg::MODE_LOAD, 10'(c), 10'(r), $urandom);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain outstanding results, then set up a new source size and step
  task automatic set_geometry(input int w, input int h, input int xs, input int ys);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    reg_write(btr_pkg::REG_SOURCE_WIDTH,
              {$urandom_range(1, 0) ? 23'($urandom) : 23'd0, 9'(w)});
    reg_write(btr_pkg::REG_SOURCE_HEIGHT,
              {$urandom_range(1, 0) ? 23'($urandom) : 23'd0, 9'(h)});
    reg_write(btr_pkg::REG_X_STEP, {$urandom_range(1, 0) ? 7'($urandom) : 7'd0, 25'(xs)});
    reg_write(btr_pkg::REG_Y_STEP, {$urandom_range(1, 0) ? 7'($urandom) : 7'd0, 25'(ys)});
    eff_w = (w % 512 == 0) ? 1 : ((w % 512 > 256) ? 256 : w % 512);
    eff_h = (h % 512 == 0) ? 1 : ((h % 512 > 256) ? 256 : h % 512);
  endtask

  // every pixel a request can touch must hold data first
  task automatic fill_source;
    for (int y = 0; y < eff_h; y++)
      for (int x = 0; x < eff_w; x++)
        if (!written[y*256 + x]) load_pixel(x, y);
  endtask

  task automatic mixed_traffic(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 70)
        send_request(btr_pkg::MODE_REQUEST,
                     $urandom_range(1, 0) ? 10'($urandom_range(31, 0)) : 10'($urandom),
                     $urandom_range(1, 0) ? 10'($urandom_range(31, 0)) : 10'($urandom),
                     $urandom);
      else if (pick < 90)
        load_pixel($urandom_range(eff_w - 1, 0), $urandom_range(eff_h - 1, 0));
      else
        load_pixel($urandom_range(1023, 0), $urandom_range(1023, 0));
    end
  endtask

  function automatic int pick_step;
    case ($urandom_range(4, 0))
      0: return $urandom_range(32'h10000, 0);
      1: return $urandom_range(32'h40000, 32'h10000);
      2: return $urandom_range(32'h1000000, 0);
      3: return 32'h8000;
      default: return $urandom_range(32'h18000, 32'h4000);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: 1x1 source, unit steps, extreme channel values
    send_request(btr_pkg::MODE_LOAD, 0, 0, 32'hFFFF_FFFF);
    send_request(btr_pkg::MODE_REQUEST, 0, 0, 32'h0);
    send_request(btr_pkg::MODE_REQUEST, 1023, 1023, 32'hFFFF_FFFF);
    send_request(btr_pkg::MODE_LOAD, 0, 0, 32'h0);
    send_request(btr_pkg::MODE_REQUEST, 5, 0, 32'h0);
    // loads outside the store are dropped
    send_request(btr_pkg::MODE_LOAD, 1023, 0, 32'h1234_5678);
    send_request(btr_pkg::MODE_LOAD, 0, 256, 32'h1234_5678);
    send_request(btr_pkg::MODE_REQUEST, 0, 1023, 32'h0);

    // 2x2 with half steps: both lerp directions, edge copies, clamping
    set_geometry(2, 2, 32'h8000, 32'h8000);
    send_request(btr_pkg::MODE_LOAD, 0, 0, 32'h00FF_00FF);
    send_request(btr_pkg::MODE_LOAD, 1, 0, 32'hFF00_FF00);
    send_request(btr_pkg::MODE_LOAD, 0, 1, 32'h80_01_FE_7F);
    send_request(btr_pkg::MODE_LOAD, 1, 1, 32'h01_80_7F_FE);
    for (int i = 0; i < 4; i++) send_request(btr_pkg::MODE_REQUEST, i, i ^ 1, 32'h0);
    send_request(btr_pkg::MODE_REQUEST, 1023, 1, 32'h0);
    send_request(btr_pkg::MODE_REQUEST, 1, 1023, 32'h0);

    // zero dimensions count as one, zero steps
    set_geometry(0, 0, 0, 0);
    mixed_traffic(10);
    // oversized width, max step; then oversized height
    set_geometry(511, 1, 32'h1000000, 32'h1000000);
    fill_source();
    mixed_traffic(40);
    set_geometry(2, 511, 32'h8001, 32'hFFFF);
    fill_source();
    mixed_traffic(40);
    // full size with max step only reaches the first and last column and row
    set_geometry(256, 256, 32'h1000000, 32'h1000000);
    load_pixel(255, 1);
    load_pixel(255, 255);
    mixed_traffic(20);

    for (int p = 0; p < 10; p++) begin
      set_geometry($urandom_range(20, 1), $urandom_range(16, 1), pick_step(), pick_step());
      fill_source();
      mixed_traffic(35);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests (loads and resample requests) over 16 source geometries,",
             sent);
    $display("including clamped sizes and steps; %0d resampled pixels checked.", results);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/btr_pkg.sv
src/btr_ram.sv
src/bilinear_texture_resampler.sv
verif/btr_checker.sv
verif/tb.sv
